[hw/rtl/grbp_pkg.sv]
// Package for the gamma breathing RGB PWM block: tick codes, the gamma
// brightness table, button toggle masks and the state record.
// No dependencies.
package grbp_pkg;

   // Number of gamma steps in use; the fade index tops out below it.
   localparam int GAMMA_STEPS = 64;

   // Highest fade index: the last gamma step, never above the table end.
   localparam logic [5:0] TOP_INDEX = 6'((GAMMA_STEPS - 1 < 63) ? GAMMA_STEPS - 1 : 63);

   // Reset values of the control state.
   localparam logic [7:0] THRESHOLD_RESET = 8'd10;
   localparam logic [2:0] ENABLE_RESET    = 3'b010;

   // Tick selector codes; the fourth code is a no-op.
   typedef enum logic [1:0] {
      TICK_PWM  = 2'd0,
      TICK_FADE = 2'd1,
      TICK_SCAN = 2'd2
   } tick_type;

   // Gamma brightness table; the top entry is full scale and is used at the top fade index.
   localparam logic [8:0] GAMMA_TABLE [64] = '{
      9'd0,   9'd1,   9'd1,   9'd1,   9'd1,   9'd1,   9'd2,   9'd2,
      9'd2,   9'd2,   9'd2,   9'd3,   9'd3,   9'd3,   9'd3,   9'd4,
      9'd4,   9'd5,   9'd5,   9'd5,   9'd6,   9'd7,   9'd7,   9'd8,
      9'd9,   9'd9,   9'd10,  9'd11,  9'd12,  9'd13,  9'd14,  9'd16,
      9'd17,  9'd19,  9'd21,  9'd22,  9'd24,  9'd27,  9'd29,  9'd32,
      9'd35,  9'd38,  9'd41,  9'd45,  9'd49,  9'd54,  9'd58,  9'd64,
      9'd70,  9'd76,  9'd83,  9'd90,  9'd99,  9'd107, 9'd117, 9'd128,
      9'd139, 9'd152, 9'd166, 9'd181, 9'd197, 9'd215, 9'd235, 9'd256
   };

   // Enable bits flipped by each button: none, red, blue, green.
   localparam logic [2:0] TOGGLE_MASK [4] = '{3'b000, 3'b001, 3'b100, 3'b010};

   // Tick state of the block, updated once per accepted beat.
   typedef struct packed {
      logic [5:0]       fade_index;
      logic             fade_rising;
      logic [2:0][7:0]  duty_counts;
      logic [2:0]       pin_levels;
      logic [2:0]       enable_bits;
      logic [3:0][7:0]  press_counts;
   } state_type;

endpackage

[hw/rtl/grbp_tick_update.sv]
// Next-state logic for one tick: PWM duty counters, fade stepping and the
// button scan chain. Depends on grbp_pkg.
module grbp_tick_update
   import grbp_pkg::*;
(
   input  state_type   state_cur,
   input  logic [1:0]  tick_sel,
   input  logic [3:0]  button_levels,
   input  logic [7:0]  press_threshold,
   output state_type   state_nxt
);

   logic [5:0] gamma_index;
   logic [8:0] duty_limit;
   logic [6:0] fade_step;
   logic       scan_done;

   // Clamp the table index to the top step and look up the duty limit.
   assign gamma_index = (state_cur.fade_index > TOP_INDEX) ? TOP_INDEX : state_cur.fade_index;
   assign duty_limit  = GAMMA_TABLE[gamma_index];

   // Fade step before bouncing at the ends.
   always_comb begin
      if (state_cur.fade_rising) begin
         fade_step = {1'b0, state_cur.fade_index} + 7'd1;
      end else if (state_cur.fade_index == 6'd0) begin
         fade_step = 7'd0;
      end else begin
         fade_step = {1'b0, state_cur.fade_index} - 7'd1;
      end
   end

   // Apply the selected tick to the state.
   always_comb begin
      state_nxt = state_cur;
      scan_done = 1'b0;
      case (tick_sel)
         TICK_PWM: begin
            for (int c = 0; c < 3; c++) begin
               if (state_cur.enable_bits[c]) begin
                  if ({1'b0, state_cur.duty_counts[c]} < duty_limit) begin
                     state_nxt.duty_counts[c] = state_cur.duty_counts[c] + 8'd1;
                     state_nxt.pin_levels[c]  = 1'b0;
                  end else begin
                     state_nxt.duty_counts[c] = 8'd0;
                     state_nxt.pin_levels[c]  = 1'b1;
                  end
               end
            end
         end
         TICK_FADE: begin
            state_nxt.fade_index = fade_step[5:0];
            if (fade_step <= 7'd1) begin
               state_nxt.fade_index  = 6'd1;
               state_nxt.fade_rising = 1'b1;
            end
            if (fade_step >= {1'b0, TOP_INDEX}) begin
               state_nxt.fade_index  = TOP_INDEX;
               state_nxt.fade_rising = 1'b0;
            end
         end
         TICK_SCAN: begin
            // The first button that is pressed, or released after a long
            // enough press, acts; the rest are skipped.
            for (int b = 0; b < 4; b++) begin
               if (!scan_done) begin
                  if (!button_levels[b]) begin
                     state_nxt.press_counts[b] = state_cur.press_counts[b] + 8'd1;
                     scan_done = 1'b1;
                  end else if (state_cur.press_counts[b] > press_threshold) begin
                     state_nxt.enable_bits     = state_cur.enable_bits ^ TOGGLE_MASK[b];
                     state_nxt.press_counts[b] = 8'd0;
                     scan_done = 1'b1;
                  end
               end
            end
         end
         default: begin
            state_nxt = state_cur;
         end
      endcase
   end

endmodule

[hw/rtl/gamma_breathing_rgb_pwm.sv]
// Top level of the gamma breathing RGB PWM block: handshakes, state and
// threshold registers. Depends on grbp_pkg and grbp_tick_update.
//
// Usage: each beat on the req_ channel is one tick of a time base chosen
// by req_type (PWM, fade step or button scan; the unused code changes
// nothing). Every beat yields exactly one beat on the rsp_ channel that
// reports the pin levels, fade level and color enables after that tick.
// Latency: the result is valid in the cycle after the request is accepted.
// Throughput: one beat per cycle; the whole tick update is one pass of
// counter and compare logic feeding the state register, which also serves
// as the result register.
// Stall: while a result waits with rsp_ready low, req_ready is low; a new
// request is taken in the same cycle the waiting result is taken.
// Reset: synchronous; fade index 0 and rising, counters and pins clear,
// green alone enabled, press threshold 10, no result pending.
// The press threshold is written through csr_write_enable/csr_write_data;
// the user must write it only while the block is idle; the block does not enforce this.
module gamma_breathing_rgb_pwm
   import grbp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_type,
   input  logic [3:0] req_button_levels,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_red_pin,
   output logic       rsp_green_pin,
   output logic       rsp_blue_pin,
   output logic [5:0] rsp_fade_level,
   output logic [2:0] rsp_color_enables,
   input  logic       csr_write_enable,
   input  logic [7:0] csr_write_data
);

   state_type  state_ff;
   state_type  state_in;
   state_type  state_upd;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   logic [7:0] threshold_ff;
   logic [7:0] threshold_in;
   logic       req_accept;

   // A request is taken when no result waits or the waiting one leaves now.
   assign req_ready  = !rsp_valid_ff || rsp_ready;
   assign req_accept = req_valid && req_ready;

   grbp_tick_update u_update (
      .state_cur       (state_ff),
      .tick_sel        (req_type),
      .button_levels   (req_button_levels),
      .press_threshold (threshold_ff),
      .state_nxt       (state_upd)
   );

   // State advances only on an accepted beat.
   assign state_in     = req_accept ? state_upd : state_ff;
   assign rsp_valid_in = req_accept || (rsp_valid_ff && !rsp_ready);
   assign threshold_in = csr_write_enable ? csr_write_data : threshold_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.fade_index   <= 6'd0;
         state_ff.fade_rising  <= 1'b1;
         state_ff.duty_counts  <= '0;
         state_ff.pin_levels   <= 3'b000;
         state_ff.enable_bits  <= ENABLE_RESET;
         state_ff.press_counts <= '0;
         rsp_valid_ff          <= 1'b0;
         threshold_ff          <= THRESHOLD_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         threshold_ff <= threshold_in;
      end
   end

   // The result reports the state left by the last accepted tick.
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_red_pin       = state_ff.pin_levels[0];
   assign rsp_green_pin     = state_ff.pin_levels[1];
   assign rsp_blue_pin      = state_ff.pin_levels[2];
   assign rsp_fade_level    = state_ff.fade_index;
   assign rsp_color_enables = state_ff.enable_bits;

`ifndef SYNTHESIS
   // A fade tick always leaves the index between 1 and the top index.
   assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_type == TICK_FADE) |=>
         (state_ff.fade_index >= 6'd1 && state_ff.fade_index <= TOP_INDEX))
      else $error("fade index outside bounce range after fade tick");

   // Enables change only on an accepted scan tick.
   assert property (@(posedge clock) disable iff (reset)
      !(req_accept && req_type == TICK_SCAN) |=> $stable(state_ff.enable_bits))
      else $error("color enables changed without a scan tick");

   // The fade index changes only on an accepted fade tick.
   assert property (@(posedge clock) disable iff (reset)
      !(req_accept && req_type == TICK_FADE) |=> $stable(state_ff.fade_index))
      else $error("fade index changed without a fade tick");

   // Duty counters and pins change only on an accepted PWM tick.
   assert property (@(posedge clock) disable iff (reset)
      !(req_accept && req_type == TICK_PWM) |=>
         ($stable(state_ff.duty_counts) && $stable(state_ff.pin_levels)))
      else $error("PWM state changed without a PWM tick");
`endif

endmodule
